>>> design/rptm_pkg.sv
`default_nettype none
package rptm_pkg;

   localparam int DefPoolPages = 64;
   localparam int FrameWidth   = 40;
   localparam int VpageWidth   = 45;
   localparam int CountWidth   = 20;
   localparam int IdxWidth     = 9;
   localparam int EntryWidth   = 64;
   localparam int EntriesPerTable = 512;

   localparam logic [1:0] KIND_MAP  = 2'd0;
   localparam logic [1:0] KIND_SELF = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   localparam logic CSR_POOL_BASE = 1'b0;
   localparam logic CSR_FIVE_LVL  = 1'b1;

   localparam logic [IdxWidth-1:0] IDX_MASK = 9'h1FF;
   localparam logic [2:0] MAX_LEVELS = 3'd5;
   localparam logic [11:0] PTE_VW = 12'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PAGE,
      ST_RD,
      ST_CHK,
      ST_ZERO,
      ST_LEAF,
      ST_SELF,
      ST_READ_RD,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   function automatic logic [EntryWidth-1:0] make_entry(input logic [FrameWidth-1:0] frame);
      make_entry = {{(EntryWidth-FrameWidth-12){1'b0}}, frame, PTE_VW};
   endfunction

endpackage
`default_nettype wire

>>> design/rptm_store.sv
`default_nettype none
module rptm_store
   import rptm_pkg::*;
#(
   parameter int AddrWidth = 15
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AddrWidth-1:0]  wr_addr,
   input  wire logic [EntryWidth-1:0] wr_data,
   input  wire logic [AddrWidth-1:0]  rd_addr,
   output logic      [EntryWidth-1:0] rd_data
);

   logic [EntryWidth-1:0] mem [2**AddrWidth];

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> design/radix_page_table_mapper_unit.sv
// Radix page table mapper: builds four- or five-level page tables in an on-chip
// pool of POOL_PAGES table pages (512 x 64-bit entries each) held in one
// single-port-write, registered-read memory. After reset a clearing pass writes
// every entry to zero, during which no request is taken. Each mapped page is
// started in ST_PAGE, then walks each table level in two steps (read, then
// check the registered data) and ends with the leaf write; a new table adds a
// zero fill of all its entries. The response is loaded in ST_DONE, after
// ST_SELF for self-map items, ST_PAGE for empty runs and ST_READ_RD and
// ST_READ_WAIT for reads, and the unit then returns to idle to take the next
// request. The response sits in its own register, so a stalled response holds
// back only the loading of the next response, and with it further requests.
// One transaction is in flight at a time; the memory port sets the pace.
`default_nettype none
module radix_page_table_mapper_unit
   import rptm_pkg::*;
#(
   parameter int POOL_PAGES = DefPoolPages
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request: kind, virtual_page, physical_frame, page_count, table_page, table_entry
   input  wire logic [127:0] req_tdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // response: status, entry_value, pages_done
   output logic [87:0]       rsp_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_index,
   input  wire logic [39:0]  csr_data,
   input  wire logic         csr_valid,
   output logic              csr_ready
);

   localparam int PageWidth = $clog2(POOL_PAGES + 1);
   localparam int PgIdxW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
   localparam int AddrWidth = PgIdxW + IdxWidth;
   localparam int ClrWidth  = AddrWidth + 1;

   state_type state_ff, state_in;

   logic [FrameWidth-1:0] base_ff, base_in;
   logic                  five_ff, five_in;
   logic [PageWidth-1:0]  free_ff, free_in;
   logic [ClrWidth-1:0]   clr_ff, clr_in;
   logic [1:0]            kind_ff, kind_in;
   logic [VpageWidth-1:0] vpage_ff, vpage_in;
   logic [FrameWidth-1:0] frame_ff, frame_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] done_ff, done_in;
   logic [5:0]            tpage_ff, tpage_in;
   logic [IdxWidth-1:0]   tentry_ff, tentry_in;
   logic [2:0]            lvl_ff, lvl_in;
   logic [PgIdxW-1:0]     page_ff, page_in;
   logic [PgIdxW-1:0]     zpage_ff, zpage_in;
   logic [IdxWidth-1:0]   zcnt_ff, zcnt_in;
   logic                  status_ff, status_in;
   logic [EntryWidth-1:0] value_ff, value_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [87:0]           rsp_data_ff, rsp_data_in;

   logic                  wr_en;
   logic [AddrWidth-1:0]  wr_addr, rd_addr;
   logic [EntryWidth-1:0] wr_data, rd_data;

   logic [IdxWidth-1:0]   lvl_idx;
   logic [FrameWidth-1:0] rel;
   logic                  req_fire;

   rptm_store #(.AddrWidth(AddrWidth)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // level index from the virtual page
   always_comb begin
      case (lvl_ff)
         3'd5:    lvl_idx = vpage_ff[44:36];
         3'd4:    lvl_idx = vpage_ff[35:27];
         3'd3:    lvl_idx = vpage_ff[26:18];
         3'd2:    lvl_idx = vpage_ff[17:9];
         default: lvl_idx = vpage_ff[8:0];
      endcase
   end

   assign rel = rd_data[FrameWidth+11:12] - base_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == ClrWidth'(POOL_PAGES * EntriesPerTable - 1))
            state_in = ST_IDLE;
         ST_IDLE: if (req_fire) begin
            case (req_tdata[1:0])
               KIND_MAP:  state_in = ST_PAGE;
               KIND_SELF: state_in = ST_SELF;
               KIND_READ: state_in = ST_READ_RD;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_PAGE: state_in = (done_ff == count_ff) ? ST_DONE : ST_RD;
         ST_RD:   state_in = ST_CHK;
         ST_CHK: begin
            if (rd_data[0]) begin
               if (rel >= FrameWidth'(POOL_PAGES)) state_in = ST_DONE;
               else state_in = (lvl_ff == 3'd2) ? ST_LEAF : ST_RD;
            end else if (free_ff >= PageWidth'(POOL_PAGES)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: if (zcnt_ff == IDX_MASK)
            state_in = (lvl_ff == 3'd1) ? ST_LEAF : ST_RD;
         ST_LEAF:      state_in = ST_PAGE;
         ST_SELF:      state_in = ST_DONE;
         ST_READ_RD:   state_in = ST_READ_WAIT;
         ST_READ_WAIT: state_in = ST_DONE;
         ST_DONE: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      base_in = base_ff; five_in = five_ff; free_in = free_ff; clr_in = clr_ff;
      kind_in = kind_ff; vpage_in = vpage_ff; frame_in = frame_ff;
      count_in = count_ff; done_in = done_ff; tpage_in = tpage_ff;
      tentry_in = tentry_ff; lvl_in = lvl_ff; page_in = page_ff;
      zpage_in = zpage_ff; zcnt_in = zcnt_ff; status_in = status_ff;
      value_in = value_ff; rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0;
      rd_addr = {page_ff, lvl_idx};

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      if (csr_valid) begin
         if (csr_index == CSR_POOL_BASE) base_in = csr_data;
         else five_in = csr_data[0];
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff[AddrWidth-1:0];
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: if (req_fire) begin
            kind_in = req_tdata[1:0];
            vpage_in = req_tdata[46:2];
            frame_in = req_tdata[86:47];
            count_in = req_tdata[106:87];
            tpage_in = req_tdata[112:107];
            tentry_in = req_tdata[121:113];
            done_in = '0; status_in = 1'b0; value_in = '0;
         end
         ST_PAGE: begin
            page_in = '0;
            lvl_in = five_ff ? MAX_LEVELS : 3'd4;
         end
         ST_CHK: begin
            if (rd_data[0]) begin
               if (rel >= FrameWidth'(POOL_PAGES)) status_in = 1'b1;
               else begin
                  page_in = rel[PgIdxW-1:0];
                  lvl_in = lvl_ff - 1'b1;
               end
            end else if (free_ff >= PageWidth'(POOL_PAGES)) begin
               status_in = 1'b1;
            end else begin
               wr_en = 1'b1;
               wr_addr = {page_ff, lvl_idx};
               wr_data = make_entry(base_ff + FrameWidth'(free_ff));
               zpage_in = free_ff[PgIdxW-1:0];
               page_in = free_ff[PgIdxW-1:0];
               free_in = free_ff + 1'b1;
               zcnt_in = '0;
               lvl_in = lvl_ff - 1'b1;
            end
         end
         ST_ZERO: begin
            wr_en = 1'b1;
            wr_addr = {zpage_ff, zcnt_ff};
            zcnt_in = zcnt_ff + 1'b1;
         end
         ST_LEAF: begin
            wr_en = 1'b1;
            wr_addr = {page_ff, vpage_ff[8:0]};
            wr_data = make_entry(frame_ff);
            vpage_in = vpage_ff + 1'b1;
            frame_in = frame_ff + 1'b1;
            done_in = done_ff + 1'b1;
         end
         ST_SELF: begin
            wr_en = 1'b1;
            wr_addr = {{PgIdxW{1'b0}}, five_ff ? vpage_ff[44:36] : vpage_ff[35:27]};
            wr_data = make_entry(base_ff);
         end
         ST_READ_RD: rd_addr = {PgIdxW'(tpage_ff), tentry_ff};
         ST_READ_WAIT: begin
            if ({26'b0, tpage_ff} < 32'(POOL_PAGES)) value_in = rd_data;
         end
         // load the response register
         ST_DONE: if (!rsp_valid_ff || rsp_tready) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = {3'b0, done_ff, value_ff, status_ff};
            if (kind_ff != KIND_MAP) done_in = '0;
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         free_ff <= PageWidth'(1);
         base_ff <= '0;
         five_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         free_ff <= free_in;
         base_ff <= base_in;
         five_ff <= five_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in; vpage_ff <= vpage_in; frame_ff <= frame_in;
      count_ff <= count_in; done_ff <= done_in; tpage_ff <= tpage_in;
      tentry_ff <= tentry_in; lvl_ff <= lvl_in; page_ff <= page_in;
      zpage_ff <= zpage_in; zcnt_ff <= zcnt_in; status_ff <= status_in;
      value_ff <= value_in; rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

>>> test/radix_page_table_mapper_unit_tb.sv
`timescale 1ns / 1ps
module radix_page_table_mapper_unit_tb;
   import rptm_pkg::*;

   localparam int PoolPages = DefPoolPages;
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [FrameWidth-1:0] FRAME_ALL = {FrameWidth{1'b1}};
   localparam logic [VpageWidth-1:0] VPAGE_ALL = {VpageWidth{1'b1}};

   typedef struct packed {
      logic [CountWidth-1:0] pages_done;
      logic [EntryWidth-1:0] entry_value;
      logic                  status;
   } map_result_t;

   // page table builder mirror and the results it still owes
   class table_builder_model;
      logic [EntryWidth-1:0] tables [0:PoolPages*EntriesPerTable-1];
      int unsigned           free_page;
      logic [FrameWidth-1:0] base_frame;
      logic                  five_lvl;
      map_result_t           owed[$];
      int                    errors;

      function new();
         foreach (tables[i]) tables[i] = '0;
         free_page  = 1;
         base_frame = '0;
         five_lvl   = 1'b0;
         errors     = 0;
      endfunction

      function void write_csr(logic idx, logic [FrameWidth-1:0] val);
         if (idx == CSR_POOL_BASE) base_frame = val;
         else five_lvl = val[0];
      endfunction

      // follow or allocate the table behind one entry
      function bit descend(int unsigned pg, logic [IdxWidth-1:0] idx,
                           output int unsigned nxt);
         logic [EntryWidth-1:0] e;
         logic [FrameWidth-1:0] rel;
         e = tables[pg*EntriesPerTable + idx];
         if (e[0]) begin
            rel = e[12 +: FrameWidth] - base_frame;
            if (rel >= PoolPages) return 0;
            nxt = 32'(rel);
            return 1;
         end
         if (free_page >= PoolPages) return 0;
         nxt = free_page;
         free_page++;
         for (int i = 0; i < EntriesPerTable; i++) tables[nxt*EntriesPerTable + i] = '0;
         tables[pg*EntriesPerTable + idx] = {12'd0, base_frame + FrameWidth'(nxt), PTE_VW};
         return 1;
      endfunction

      function void note_request(logic [127:0] d);
         logic [1:0]            kind;
         logic [VpageWidth-1:0] vp;
         logic [FrameWidth-1:0] fr;
         logic [CountWidth-1:0] cnt;
         logic [5:0]            tpg;
         logic [IdxWidth-1:0]   tent;
         map_result_t           r;
         int unsigned           pg;
         bit                    ok;
         kind = d[1:0];
         vp   = d[46:2];
         fr   = d[86:47];
         cnt  = d[106:87];
         tpg  = d[112:107];
         tent = d[121:113];
         r = '0;
         if (kind == KIND_MAP) begin
            while (r.pages_done < cnt) begin
               pg = 0;
               ok = 1;
               for (int lvl = (five_lvl ? 5 : 4); lvl > 1; lvl--) begin
                  if (!descend(pg, vp[9*(lvl-1) +: 9], pg)) begin
                     ok = 0;
                     break;
                  end
               end
               if (!ok) begin
                  r.status = 1'b1;
                  break;
               end
               tables[pg*EntriesPerTable + vp[8:0]] = {12'd0, fr, PTE_VW};
               vp = vp + 1'b1;
               fr = fr + 1'b1;
               r.pages_done++;
            end
         end else if (kind == KIND_SELF) begin
            tables[five_lvl ? vp[44:36] : vp[35:27]] = {12'd0, base_frame, PTE_VW};
         end else if (kind == KIND_READ) begin
            if (tpg < PoolPages) r.entry_value = tables[tpg*EntriesPerTable + tent];
         end
         owed.push_back(r);
      endfunction

      function void check_result(logic [87:0] d);
         map_result_t got, want;
         got = d[84:0];
         if (owed.size() == 0) begin
            $display("%0t: unexpected response %h", $time, d);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.entry_value !== want.entry_value) begin
            $display("%0t: entry_value expected %h actual %h", $time,
                     want.entry_value, got.entry_value);
            errors++;
         end
         if (got.pages_done !== want.pages_done) begin
            $display("%0t: pages_done expected %0d actual %0d", $time,
                     want.pages_done, got.pages_done);
            errors++;
         end
         if (d[87:85] !== 3'd0) begin
            $display("%0t: pad bits expected 0 actual %b", $time, d[87:85]);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [127:0] req_tdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [87:0]  rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_index = 1'b0;
   logic [39:0]  csr_data = '0;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   bit           steady = 1'b0;

   table_builder_model builder = new();

   radix_page_table_mapper_unit #(.POOL_PAGES(PoolPages)) uut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_index(csr_index), .csr_data(csr_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response side backpressure
   always @(negedge clock) rsp_tready <= steady || ($urandom_range(99) >= 14);

   // response transaction check
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) builder.check_result(rsp_tdata);

   function automatic logic [127:0] pack_req(logic [1:0] kind, logic [VpageWidth-1:0] vp,
                                             logic [FrameWidth-1:0] fr,
                                             logic [CountWidth-1:0] cnt,
                                             logic [5:0] tpg, logic [IdxWidth-1:0] tent);
      return {6'd0, tent, tpg, cnt, fr, vp, kind};
   endfunction

   task automatic send_req(logic [127:0] d);
      while (!steady && $urandom_range(99) < 14) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      builder.note_request(d);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (builder.owed.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [39:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      builder.write_csr(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [VpageWidth-1:0] rand_vpage();
      return VpageWidth'({$urandom, $urandom});
   endfunction

   function automatic logic [FrameWidth-1:0] rand_frame();
      return FrameWidth'({$urandom, $urandom});
   endfunction

   task automatic random_items(int n, int quiet_from, int quiet_to);
      logic [VpageWidth-1:0] vp;
      logic [CountWidth-1:0] cnt;
      int                    r;
      for (int i = 0; i < n; i++) begin
         steady = (i >= quiet_from && i < quiet_to);
         r = $urandom_range(99);
         // most maps land in a few regions so tables get reused
         if ($urandom_range(9) == 0) vp = rand_vpage();
         else vp = {$urandom_range(1, 0) == 1 ? 9'h1A5 : 9'h000, 9'h000,
                    9'($urandom_range(1)), 9'($urandom_range(3)), 9'($urandom)};
         cnt = ($urandom_range(4) == 0) ? CountWidth'($urandom_range(64))
                                        : CountWidth'($urandom_range(8));
         if (r < 55)
            send_req(pack_req(KIND_MAP, vp, rand_frame(), cnt, 6'($urandom),
                              9'($urandom)));
         else if (r < 62)
            send_req(pack_req(KIND_SELF, rand_vpage(), rand_frame(), 20'($urandom),
                              6'($urandom), 9'($urandom)));
         else if (r < 93)
            send_req(pack_req(KIND_READ, rand_vpage(), rand_frame(), 20'($urandom),
                              6'($urandom_range(builder.free_page + 1)), 9'($urandom)));
         else
            send_req(pack_req(KIND_NONE, rand_vpage(), rand_frame(), 20'($urandom),
                              6'($urandom), 9'($urandom)));
         if (i == n / 2) drain();
      end
      steady = 1'b0;
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: base settings
      write_csr(CSR_POOL_BASE, 40'd0);
      write_csr(CSR_FIVE_LVL, 40'd0);
      send_req(pack_req(KIND_MAP, 45'd5, 40'd7, 20'd0, 6'd0, 9'd0));
      send_req(pack_req(KIND_MAP, 45'd0, 40'd0, 20'd1, 6'd0, 9'd0));
      send_req(pack_req(KIND_MAP, 45'd510, FRAME_ALL - 1'b1, 20'd4, 6'd0, 9'd0));
      send_req(pack_req(KIND_MAP, VPAGE_ALL, 40'd100, 20'd2, 6'd0, 9'd0));
      send_req(pack_req(KIND_SELF, {9'd0, 9'd300, 27'd0}, 40'd0, 20'd0, 6'd0, 9'd0));
      send_req(pack_req(KIND_MAP, {9'd0, 9'd300, 27'd0}, 40'd55, 20'd3, 6'd0, 9'd0));
      send_req(pack_req(KIND_READ, 45'd0, 40'd0, 20'd0, 6'd0, 9'd300));
      send_req(pack_req(KIND_READ, 45'd0, 40'd0, 20'd0, 6'd0, 9'd0));
      send_req(pack_req(KIND_READ, 45'd0, 40'd0, 20'd0, 6'd3, 9'd511));
      send_req(pack_req(KIND_READ, 45'd0, 40'd0, 20'd0, 6'd63, 9'd511));
      send_req(pack_req(KIND_NONE, VPAGE_ALL, FRAME_ALL, 20'hFFFFF, 6'd63, 9'd511));
      drain();

      random_items(600, 250, 450);

      // five-level walks
      write_csr(CSR_FIVE_LVL, 40'd1);
      send_req(pack_req(KIND_MAP, {9'h1FF, 36'd0}, 40'd9, 20'd2, 6'd0, 9'd0));
      send_req(pack_req(KIND_SELF, {9'd77, 36'd0}, 40'd0, 20'd0, 6'd0, 9'd0));
      send_req(pack_req(KIND_READ, 45'd0, 40'd0, 20'd0, 6'd0, 9'd77));
      drain();
      random_items(500, -1, -1);

      // moved pool base: old entries leave the pool
      write_csr(CSR_FIVE_LVL, 40'd0);
      write_csr(CSR_POOL_BASE, 40'h80_0000_0000);
      send_req(pack_req(KIND_MAP, 45'd0, 40'd1, 20'hFFFFF, 6'd0, 9'd0));
      drain();
      random_items(300, -1, -1);

      write_csr(CSR_POOL_BASE, FRAME_ALL);
      write_csr(CSR_FIVE_LVL, 40'd1);
      random_items(300, -1, -1);

      if (builder.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #300_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> files.f
design/rptm_pkg.sv
design/rptm_store.sv
design/radix_page_table_mapper_unit.sv
test/radix_page_table_mapper_unit_tb.sv
